FILE: design/tcgr_pkg.sv
// Shared constants and helper functions for the text console glyph renderer.
package tcgr_pkg;

  localparam int GLYPH_COUNT    = 256;
  localparam int GLYPH_W        = 9;
  localparam int GLYPH_H        = 14;
  localparam int FONT_BYTES     = 8064;
  localparam int BANKS          = 4;
  localparam int BANK_DEPTH     = FONT_BYTES / BANKS;
  localparam int BANK_AW        = $clog2(BANK_DEPTH);
  localparam int ROW_BITS       = 2 * GLYPH_W;
  localparam int CFG_IDX_W      = 4;

  localparam logic [15:0] MARGIN_H = 16'd90;
  localparam logic [15:0] MARGIN_V = 16'd70;

  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  localparam logic CMD_FONT_WRITE = 1'b0;
  localparam logic CMD_CHARACTER  = 1'b1;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  // Adds two 16-bit values and clamps the sum at the largest 16-bit value.
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: design/text_console_glyph_renderer.sv
// Text console glyph renderer: font store, pixel cursor and glyph row sequencer.
//
// Usage: requests arrive on the in_ channel (valid/stall). A font request
// (command 0) writes one byte of the 8064-byte font store and produces nothing.
// A character request either moves the cursor (carriage return, line feed) or
// renders fourteen glyph rows on the out_ channel, optionally followed by a
// scroll-up result; NUL renders no rows. A character's last result has out_last.
// The block takes one request at a time and holds in_stall high while it
// works. Font writes, carriage return and line feed are done without leaving
// idle. A glyph passes through the advance, wrap and scroll set-up states and
// then the row state, which reads the four byte banks once per row and passes
// each row through the bank read data and the output register; a scroll
// result follows from its own state. A NUL skips the row state.
// A stalled receiver simply holds the output register; the bank read data
// is held too, so the sequencer pauses without losing a row.
// Screen size registers are written on the cfg_ channel, which is always
// ready; writes are expected only while the block is idle.
// Reset (rst_n low, synchronous) sets the screen to 1024 x 768 and the cursor
// to (90, 70). The font store is not cleared and must be loaded before use.
module text_console_glyph_renderer
  import tcgr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [7:0]           in_character,
  input  logic [12:0]          in_font_address,
  input  logic [7:0]           in_font_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [15:0]          out_row_x,
  output logic [15:0]          out_row_y,
  output logic [17:0]          out_levels,
  output logic                 out_last,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ADV     = 6'b000010,
    ST_WRAP    = 6'b000100,
    ST_SCROLL  = 6'b001000,
    ST_ROWS    = 6'b010000,
    ST_SCR_OUT = 6'b100000
  } state_t;

  state_t       state_r, state_nxt;

  logic [15:0]  width_r, height_r;
  logic [15:0]  cursor_x_r, cursor_x_nxt;
  logic [15:0]  cursor_y_r, cursor_y_nxt;
  // Cursor position that the current character leaves behind.
  logic [15:0]  ncx_r, ncx_nxt;
  logic [15:0]  ncy_r, ncy_nxt;
  logic         scroll_r, scroll_nxt;
  logic         ch_nz_r, ch_nz_nxt;
  logic         glyph_ok_r, glyph_ok_nxt;
  logic [GLYPH_W-1:0] xmask_r, xmask_nxt;

  // Bit pointer into the font store for the row being read.
  logic [15:0]  ptr_r, ptr_nxt;
  logic [3:0]   issued_r, issued_nxt;
  logic [16:0]  y_r, y_nxt;

  // Read stage: bank data plus what is needed to form the row.
  logic         rd_valid_r, rd_valid_nxt;
  logic [1:0]   rd_sel_r;
  logic [2:0]   rd_off_r;
  logic [16:0]  rd_y_r;
  logic         rd_last_r;
  logic [7:0]   rdata_r [BANKS];
  logic [BANK_AW-1:0] rd_row [BANKS];

  logic         out_valid_r, out_valid_nxt;
  logic         out_kind_r;
  logic [15:0]  out_row_x_r, out_row_y_r;
  logic [17:0]  out_levels_r;
  logic         out_last_r;

  logic         in_accept;
  logic         font_we;
  logic         issue;
  logic         out_free;
  logic         row_load;
  logic         scr_load;
  logic [12:0]  byte_addr;
  logic [17:0]  row_levels;
  logic [15:0]  row_y_sat;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign font_we   = in_accept && (in_command == CMD_FONT_WRITE)
                     && (in_font_address < 13'(FONT_BYTES));
  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid_r || !out_stall;
  assign issue     = (state_r == ST_ROWS) && (issued_r < 4'(GLYPH_H))
                     && (!rd_valid_r || out_free);
  assign row_load  = (state_r == ST_ROWS) && rd_valid_r && out_free;
  assign scr_load  = (state_r == ST_SCR_OUT) && out_free;
  assign byte_addr = ptr_r[15:3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1024;
      height_r <= 16'd768;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SCREEN_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == REG_SCREEN_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Bank read addresses. The three bytes of a row are consecutive, so they
  // always fall in three different banks; the fourth bank is unused.
  always_comb begin
    logic [1:0]  d;
    logic [12:0] a;
    for (int b = 0; b < BANKS; b++) begin
      d = 2'(b) - byte_addr[1:0];
      a = byte_addr + 13'(d);
      rd_row[b] = (d == 2'd3) ? byte_addr[12:2] : a[12:2];
    end
  end

  // Font store: four byte banks, each written at one address and read at one.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [7:0] bank_mem [0:BANK_DEPTH-1];
    always_ff @(posedge clk) begin
      if (font_we && (in_font_address[1:0] == 2'(b))) begin
        bank_mem[in_font_address[12:2]] <= in_font_byte;
      end
      if (issue) begin
        rdata_r[b] <= bank_mem[rd_row[b]];
      end
    end
  end

  // Row formation: pick the 18 bits of the row from three bytes, then mask
  // pixels that fall outside the screen.
  always_comb begin
    logic [23:0] word;
    logic [23:0] shifted;
    logic        y_out;
    word       = {rdata_r[rd_sel_r], rdata_r[rd_sel_r + 2'd1], rdata_r[rd_sel_r + 2'd2]};
    shifted    = word << rd_off_r;
    y_out      = rd_y_r >= {1'b0, height_r};
    row_levels = shifted[23:6];
    for (int p = 0; p < GLYPH_W; p++) begin
      if (!xmask_r[p] || y_out || !glyph_ok_r) begin
        row_levels[ROW_BITS-1-2*p -: 2] = 2'b00;
      end
    end
    row_y_sat = rd_y_r[16] ? 16'hFFFF : rd_y_r[15:0];
  end

  // Sequencer.
  always_comb begin
    logic [16:0] sum;
    state_nxt    = state_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    ncx_nxt      = ncx_r;
    ncy_nxt      = ncy_r;
    scroll_nxt   = scroll_r;
    ch_nz_nxt    = ch_nz_r;
    glyph_ok_nxt = glyph_ok_r;
    xmask_nxt    = xmask_r;
    ptr_nxt      = ptr_r;
    issued_nxt   = issued_r;
    y_nxt        = y_r;
    sum          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_command == CMD_CHARACTER)) begin
          if (in_character == CHAR_CR) begin
            cursor_x_nxt = MARGIN_H;
          end else if (in_character == CHAR_LF) begin
            cursor_x_nxt = MARGIN_H;
            cursor_y_nxt = sat_add16(cursor_y_r, 16'(GLYPH_H));
          end else begin
            ch_nz_nxt    = (in_character != CHAR_NUL);
            glyph_ok_nxt = ({1'b0, in_character} < 9'(GLYPH_COUNT));
            // Glyph start bit is the code times 252, that is 256 less 4.
            ptr_nxt      = {in_character, 8'b0} - {6'b0, in_character, 2'b0};
            state_nxt    = ST_ADV;
          end
        end
      end
      ST_ADV: begin
        ncx_nxt    = ch_nz_r ? sat_add16(cursor_x_r, 16'(GLYPH_W)) : cursor_x_r;
        y_nxt      = {1'b0, cursor_y_r};
        issued_nxt = '0;
        for (int p = 0; p < GLYPH_W; p++) begin
          xmask_nxt[p] = ({1'b0, cursor_x_r} + 17'(p)) < {1'b0, width_r};
        end
        state_nxt  = ST_WRAP;
      end
      ST_WRAP: begin
        sum = {1'b0, ncx_r} + {1'b0, MARGIN_H};
        if (sum >= {1'b0, width_r}) begin
          ncx_nxt = MARGIN_H;
          ncy_nxt = sat_add16(cursor_y_r, 16'(GLYPH_H));
        end else begin
          ncy_nxt = cursor_y_r;
        end
        state_nxt = ST_SCROLL;
      end
      ST_SCROLL: begin
        sum = {1'b0, ncy_r} + {1'b0, MARGIN_V};
        if (sum >= {1'b0, height_r}) begin
          scroll_nxt = 1'b1;
          ncy_nxt    = (ncy_r >= 16'(GLYPH_H)) ? ncy_r - 16'(GLYPH_H) : 16'd0;
        end else begin
          scroll_nxt = 1'b0;
        end
        if (ch_nz_r) begin
          state_nxt = ST_ROWS;
        end else if (scroll_nxt) begin
          state_nxt = ST_SCR_OUT;
        end else begin
          cursor_x_nxt = ncx_r;
          cursor_y_nxt = ncy_nxt;
          state_nxt    = ST_IDLE;
        end
      end
      ST_ROWS: begin
        if (issue) begin
          ptr_nxt    = ptr_r + 16'(ROW_BITS);
          issued_nxt = issued_r + 4'd1;
          y_nxt      = y_r + 17'd1;
        end
        if ((issued_r == 4'(GLYPH_H)) && !rd_valid_r) begin
          cursor_x_nxt = ncx_r;
          cursor_y_nxt = ncy_r;
          state_nxt    = scroll_r ? ST_SCR_OUT : ST_IDLE;
        end
      end
      ST_SCR_OUT: begin
        if (out_free) begin
          cursor_x_nxt = ncx_r;
          cursor_y_nxt = ncy_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_valid_nxt  = issue ? 1'b1 : (row_load ? 1'b0 : rd_valid_r);
  assign out_valid_nxt = (row_load || scr_load) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_x_r  <= MARGIN_H;
      cursor_y_r  <= MARGIN_V;
      scroll_r    <= 1'b0;
      issued_r    <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      scroll_r    <= scroll_nxt;
      issued_r    <= issued_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    ncx_r      <= ncx_nxt;
    ncy_r      <= ncy_nxt;
    ch_nz_r    <= ch_nz_nxt;
    glyph_ok_r <= glyph_ok_nxt;
    xmask_r    <= xmask_nxt;
    ptr_r      <= ptr_nxt;
    y_r        <= y_nxt;
    if (issue) begin
      rd_sel_r  <= byte_addr[1:0];
      rd_off_r  <= ptr_r[2:0];
      rd_y_r    <= y_r;
      rd_last_r <= (issued_r == 4'(GLYPH_H - 1));
    end
    if (row_load) begin
      out_kind_r   <= KIND_ROW;
      out_row_x_r  <= cursor_x_r;
      out_row_y_r  <= row_y_sat;
      out_levels_r <= row_levels;
      out_last_r   <= rd_last_r && !scroll_r;
    end else if (scr_load) begin
      out_kind_r   <= KIND_SCROLL;
      out_row_x_r  <= 16'd0;
      out_row_y_r  <= 16'd0;
      out_levels_r <= 18'd0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_row_x  = out_row_x_r;
  assign out_row_y  = out_row_y_r;
  assign out_levels = out_levels_r;
  assign out_last   = out_last_r;

endmodule

FILE: verif/text_console_glyph_renderer_test.sv
// Self-checking testbench for the text console glyph renderer.
module text_console_glyph_renderer_test;
  import tcgr_pkg::*;

  // Everything in this bench is timed from the falling edge for driving and from
  // the rising edge for sampling, so no check depends on event order in a step.
  localparam int CLK_HALF        = 5;
  localparam int TIMEOUT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES   = 32;
  localparam int RANDOM_REQUESTS = 32;
  localparam int PHASE_LENGTH    = 8;
  localparam int REPORT_LIMIT    = 10;
  localparam int GLYPH_BITS      = GLYPH_W * GLYPH_H * 2;

  // Glyphs given fixed contents at load time: one with every level at three and
  // one with every level at zero.
  localparam logic [7:0] FULL_GLYPH  = 8'd1;
  localparam logic [7:0] BLANK_GLYPH = 8'd2;
  localparam logic [7:0] LAST_GLYPH  = 8'(GLYPH_COUNT - 1);
  // The top font address folds onto byte 127 if the upper address bits are
  // dropped; that byte belongs to glyph 4.
  localparam logic [12:0] TOP_ADDRESS     = '1;
  localparam logic [7:0]  TOP_ALIAS_GLYPH = 8'(((TOP_ADDRESS - FONT_BYTES) * 8) / GLYPH_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = REG_SCREEN_HEIGHT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = '1;

  localparam logic [15:0] WIDTH_RESET  = 16'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;
  localparam logic [15:0] WIDTH_MIN    = 16'd181;
  localparam logic [15:0] HEIGHT_MIN   = 16'd155;
  localparam logic [15:0] EXTENT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] row_x;
    logic [15:0] row_y;
    logic [17:0] levels;
    logic        last;
  } glyph_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PULSE} stall_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [7:0]           in_character;
  logic [12:0]          in_font_address;
  logic [7:0]           in_font_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_kind;
  logic [15:0]          out_row_x;
  logic [15:0]          out_row_y;
  logic [17:0]          out_levels;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Our own view of the block: font contents, cursor and screen size.
  // The cursor is kept 32 bits wide so that margin sums never wrap.
  logic [7:0]    font_copy [FONT_BYTES];
  int unsigned   cursor_col;
  int unsigned   cursor_line;
  int unsigned   screen_cols;
  int unsigned   screen_lines;

  glyph_result_t pending_results[$];
  glyph_result_t oldest_result;
  int unsigned   mismatch_count;
  int unsigned   burst_left;
  stall_mode_t   stall_mode;
  int unsigned   stall_phase;

  text_console_glyph_renderer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_character    (in_character),
    .in_font_address (in_font_address),
    .in_font_byte    (in_font_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_row_x       (out_row_x),
    .out_row_y       (out_row_y),
    .out_levels      (out_levels),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamp16(input int unsigned value);
    return (value > 32'hFFFF) ? 32'hFFFF : value;
  endfunction

  // Works out what one accepted request does to the console and queues the
  // results it must produce. A font write and the cursor controls produce
  // nothing; a printable character produces fourteen rows, and any character
  // other than the controls may add a scroll result once the cursor has passed
  // the bottom margin. The final result of a character carries the last flag.
  task automatic predict_request(input logic cmd, input logic [7:0] code,
                                 input logic [12:0] addr, input logic [7:0] data);
    glyph_result_t row;
    int unsigned   line;
    int unsigned   col;
    int unsigned   bit_pos;
    int unsigned   level;
    int unsigned   k;
    int unsigned   p;
    int            produced;
    produced = 0;
    if (cmd == CMD_FONT_WRITE) begin
      // Addresses beyond the store are dropped without effect.
      if (addr < FONT_BYTES) font_copy[addr] = data;
    end else if (code == CHAR_CR) begin
      cursor_col = MARGIN_H;
    end else if (code == CHAR_LF) begin
      cursor_col = MARGIN_H;
      cursor_line = clamp16(cursor_line + GLYPH_H);
    end else begin
      // The NUL character draws nothing, but still runs the margin checks.
      if (code != CHAR_NUL) begin
        for (k = 0; k < GLYPH_H; k++) begin
          line = cursor_line + k;
          row = '0;
          row.kind = KIND_ROW;
          row.row_x = 16'(cursor_col);
          row.row_y = 16'(clamp16(line));
          for (p = 0; p < GLYPH_W; p++) begin
            col = cursor_col + p;
            level = 0;
            if (code < GLYPH_COUNT) begin
              bit_pos = p * 2 + code * GLYPH_BITS + k * GLYPH_W * 2;
              if ((bit_pos >> 3) < FONT_BYTES)
                level = (font_copy[bit_pos >> 3] >> (6 - (bit_pos & 7))) & 3;
            end
            // Pixels on or beyond the screen edge are never written.
            if (col >= screen_cols || line >= screen_lines) level = 0;
            row.levels[2 * (GLYPH_W - 1 - p) +: 2] = level[1:0];
          end
          pending_results.push_back(row);
          produced++;
        end
        cursor_col = clamp16(cursor_col + GLYPH_W);
      end
      if (cursor_col + MARGIN_H >= screen_cols) begin
        cursor_col = MARGIN_H;
        cursor_line = clamp16(cursor_line + GLYPH_H);
      end
      if (cursor_line + MARGIN_V >= screen_lines) begin
        cursor_line = (cursor_line >= GLYPH_H) ? cursor_line - GLYPH_H : 0;
        row = '0;
        row.kind = KIND_SCROLL;
        row.last = 1'b1;
        pending_results.push_back(row);
      end else if (produced > 0) begin
        pending_results[pending_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  // Sends one request. The sender works in bursts: at the start of each burst
  // it may hold valid low first. Valid is left high on return, so a
  // following request in the same burst goes out back to back. Every call
  // starts and ends on a falling edge.
  task automatic send_request(input logic cmd, input logic [7:0] code,
                              input logic [12:0] addr, input logic [7:0] data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_character    <= code;
    in_font_address <= addr;
    in_font_byte    <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(cmd, code, addr, data);
    @(negedge clk);
  endtask

  task automatic send_character(input logic [7:0] code);
    send_request(CMD_CHARACTER, code, 13'($urandom), 8'($urandom));
  endtask

  // Holds the sender off until every queued result has arrived, then lets the
  // block settle, since a font write may still be in flight with nothing owed.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called while the block is idle. The extra falling edge at the end keeps
  // the lowering and a following raise of cfg_valid in separate time steps.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == REG_SCREEN_WIDTH) screen_cols = value;
    else if (index == REG_SCREEN_HEIGHT) screen_lines = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Picks a screen extent, leaning towards small sizes where wrapping and
  // scrolling happen often, with the extremes of the register range included.
  function automatic logic [15:0] pick_extent(input logic [15:0] lowest);
    case ($urandom_range(0, 4))
      0:       return lowest;
      1:       return EXTENT_MAX;
      2:       return 16'($urandom_range(lowest, lowest + 250));
      3:       return 16'($urandom_range(lowest, 1200));
      default: return 16'($urandom_range(lowest, EXTENT_MAX));
    endcase
  endfunction

  // Only glyphs that have been loaded may be drawn.
  function automatic logic [7:0] loaded_glyph();
    case ($urandom_range(0, 3))
      0:       return FULL_GLYPH;
      1:       return BLANK_GLYPH;
      2:       return TOP_ALIAS_GLYPH;
      default: return LAST_GLYPH;
    endcase
  endfunction

  // Loads every byte that one glyph reads. The full and blank glyphs get fixed
  // contents, the others random bytes with the all-zero and all-one bytes
  // made common.
  task automatic load_glyph(input logic [7:0] code);
    int unsigned addr;
    logic [7:0]  data;
    for (addr = code * GLYPH_BITS / 8; addr <= ((code + 1) * GLYPH_BITS - 1) / 8; addr++) begin
      if (code == FULL_GLYPH) begin
        data = 8'hFF;
      end else if (code == BLANK_GLYPH) begin
        data = 8'h00;
      end else begin
        case ($urandom_range(0, 7))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
      end
      send_request(CMD_FONT_WRITE, 8'($urandom), 13'(addr), data);
    end
  endtask

  // The block never clears the font store and a read of an unloaded byte is
  // not allowed, so the glyphs that the tests draw are loaded first. Two
  // writes past the end of the store follow; they must change nothing.
  task automatic test_font_store();
    load_glyph(FULL_GLYPH);
    load_glyph(BLANK_GLYPH);
    load_glyph(TOP_ALIAS_GLYPH);
    load_glyph(LAST_GLYPH);
    send_request(CMD_FONT_WRITE, 8'($urandom),
                 13'(FONT_BYTES + FULL_GLYPH * GLYPH_BITS / 8 + 1), 8'h00);
    send_request(CMD_FONT_WRITE, 8'($urandom), TOP_ADDRESS,
                 ~font_copy[TOP_ADDRESS - FONT_BYTES]);
  endtask

  // Glyph contents: full levels, blank levels, the last glyph in the store and
  // the glyph that an address fold from the top address would have disturbed.
  task automatic test_glyph_contents();
    send_character(FULL_GLYPH);
    send_character(BLANK_GLYPH);
    send_character(LAST_GLYPH);
    send_character(TOP_ALIAS_GLYPH);
  endtask

  // Carriage return and line feed move the cursor without a result; the NUL
  // character draws nothing. A character after each shows where the cursor is.
  task automatic test_control_codes();
    send_character(CHAR_CR);
    send_character(FULL_GLYPH);
    send_character(CHAR_LF);
    send_character(CHAR_NUL);
    send_character(LAST_GLYPH);
  endtask

  // Walks the cursor a little way right, then narrows the screen under the
  // cursor so that part of a glyph falls past the right edge and it wraps.
  // The same is then done at the bottom, where the masked glyph is followed by
  // a scroll, and a NUL shows a scroll result standing on its own.
  task automatic test_margins_and_masking();
    send_character(CHAR_CR);
    while (cursor_col < WIDTH_MIN - 4) send_character(FULL_GLYPH);
    wait_until_quiet();
    write_register(REG_SCREEN_WIDTH, 16'(cursor_col + 4));
    send_character(FULL_GLYPH);
    wait_until_quiet();
    write_register(REG_SCREEN_WIDTH, WIDTH_RESET);
    send_character(CHAR_CR);
    while (cursor_line < HEIGHT_MIN) send_character(CHAR_LF);
    wait_until_quiet();
    write_register(REG_SCREEN_HEIGHT, 16'(cursor_line + 6));
    send_character(FULL_GLYPH);
    send_character(CHAR_NUL);
    wait_until_quiet();
    write_register(REG_SCREEN_HEIGHT, HEIGHT_RESET);
  endtask

  // Writes to indexes that hold no register must leave the screen alone; the
  // smallest legal screen is then tried, and the reset size put back.
  task automatic test_register_map();
    wait_until_quiet();
    write_register(REG_UNUSED_LOW, 16'($urandom));
    write_register(REG_UNUSED_HIGH, 16'($urandom));
    send_character(FULL_GLYPH);
    wait_until_quiet();
    write_register(REG_SCREEN_WIDTH, WIDTH_MIN);
    write_register(REG_SCREEN_HEIGHT, HEIGHT_MIN);
    send_character(CHAR_CR);
    send_character(LAST_GLYPH);
    send_character(FULL_GLYPH);
    wait_until_quiet();
    write_register(REG_SCREEN_WIDTH, WIDTH_RESET);
    write_register(REG_SCREEN_HEIGHT, HEIGHT_RESET);
  endtask

  // Mostly characters from the loaded glyphs, mixed with controls and font
  // rewrites (some past the end of the store). The screen size changes between
  // phases.
  task automatic test_random_text();
    int unsigned count;
    int unsigned pick;
    for (count = 0; count < RANDOM_REQUESTS; count++) begin
      if (count % PHASE_LENGTH == 0) begin
        wait_until_quiet();
        write_register(REG_SCREEN_WIDTH, pick_extent(WIDTH_MIN));
        write_register(REG_SCREEN_HEIGHT, pick_extent(HEIGHT_MIN));
      end
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_request(CMD_FONT_WRITE, 8'($urandom), 13'($urandom), 8'($urandom));
      else if (pick < 18) send_character(CHAR_CR);
      else if (pick < 24) send_character(CHAR_LF);
      else if (pick < 30) send_character(CHAR_NUL);
      else send_character(loaded_glyph());
    end
  endtask

  // The receiver stalls on its own schedule: stretches of no stalling, light
  // and heavy random stalling and a regular pulse, each lasting a while.
  initial begin
    out_stall = 1'b0;
    stall_phase = 0;
    stall_mode = STALL_NONE;
    forever begin
      @(negedge clk);
      if (stall_phase == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_phase = $urandom_range(20, 120);
      end
      stall_phase--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= stall_phase[1];
      endcase
    end
  end

  // Every result taken from the block is matched against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: kind %0d x %0d y %0d levels %05h last %0d",
                   out_kind, out_row_x, out_row_y, out_levels, out_last);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_kind !== oldest_result.kind || out_row_x !== oldest_result.row_x ||
            out_row_y !== oldest_result.row_y || out_levels !== oldest_result.levels ||
            out_last !== oldest_result.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch: expected kind %0d x %0d y %0d levels %05h last %0d,",
                      " got kind %0d x %0d y %0d levels %05h last %0d"},
                     oldest_result.kind, oldest_result.row_x, oldest_result.row_y,
                     oldest_result.levels, oldest_result.last,
                     out_kind, out_row_x, out_row_y, out_levels, out_last);
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_FONT_WRITE;
    in_character    = CHAR_NUL;
    in_font_address = '0;
    in_font_byte    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_SCREEN_WIDTH;
    cfg_data        = '0;
    mismatch_count  = 0;
    burst_left      = 0;
    cursor_col      = MARGIN_H;
    cursor_line     = MARGIN_V;
    screen_cols     = WIDTH_RESET;
    screen_lines    = HEIGHT_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_font_store();
    test_glyph_contents();
    test_control_codes();
    test_margins_and_masking();
    test_register_map();
    test_random_text();

    wait_until_quiet();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
